>>> hdl/bmp_to_rgb565_stream_unit_defines.svh
// Assertion macros shared by the BMP to RGB565 stream unit.
// Needs signals clk and arst_n in the scope where a macro is used.
`ifndef BMP_TO_RGB565_STREAM_UNIT_DEFINES_SVH
`define BMP_TO_RGB565_STREAM_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define BMPR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define BMPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/bmpr_pkg.sv
// Shared types, codes and constants of the BMP to RGB565 stream unit.
// No dependencies.
package bmpr_pkg;

	// Parse phase
	typedef enum logic [1:0] {
		PH_HEADER,
		PH_SKIP,
		PH_PIXELS,
		PH_DONE
	} phase_t;

	// Result kind codes
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_HEADER     = 2'd0;
	localparam kind_t KIND_PIXEL      = 2'd1;
	localparam kind_t KIND_BAD_FORMAT = 2'd2;

	// Header byte positions
	localparam logic [5:0] HB_OFFSET = 6'd10;
	localparam logic [5:0] HB_WIDTH  = 6'd18;
	localparam logic [5:0] HB_HEIGHT = 6'd22;
	localparam logic [5:0] HB_DEPTH  = 6'd28;
	localparam logic [5:0] HDR_LAST  = 6'd53;
	localparam logic [31:0] HDR_LEN  = 32'd54;

	// Supported bits per pixel
	localparam logic [15:0] DEPTH_24 = 16'd24;
	localparam logic [15:0] DEPTH_16 = 16'd16;

	// RGB565 packing masks
	localparam logic [7:0] RED_BLUE_MASK = 8'hF8;
	localparam logic [7:0] GREEN_MASK    = 8'hFC;

	// One input byte transfer
	typedef struct packed {
		logic [7:0] file_byte;
		logic       first_byte;
	} in_item_t;

	// One result transfer
	typedef struct packed {
		kind_t       kind;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [15:0] pixel;
		logic        last_pixel;
	} result_t;

endpackage

>>> hdl/bmpr_in_stage.sv
// Input register of the BMP to RGB565 stream unit.
// Uses bmpr_pkg.
module bmpr_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  logic [7:0]         file_byte,
	input  logic               first_byte,
	input  logic               advance,
	output logic               valid_s1,
	output bmpr_pkg::in_item_t item_s1
);

	logic take;

	// Hold while a registered byte cannot move on
	assign byte_stall = valid_s1 && !advance;
	assign take       = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.file_byte  <= file_byte;
			item_s1.first_byte <= first_byte;
		end
	end

endmodule

>>> hdl/bmpr_parser.sv
// Header capture, offset skip and pixel packing of the BMP stream.
// Uses bmpr_pkg and bmp_to_rgb565_stream_unit_defines.svh.
`include "bmp_to_rgb565_stream_unit_defines.svh"

module bmpr_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  bmpr_pkg::in_item_t item,
	output logic               res_valid,
	output bmpr_pkg::result_t  res
);

	bmpr_pkg::phase_t phase_q, cur_phase, nxt_phase;
	logic [5:0]  hdr_cnt_q, cur_cnt, nxt_cnt;
	logic [15:0] width_q, cur_width, nxt_width;
	logic [15:0] height_q, cur_height, nxt_height;
	logic [31:0] offset_q, cur_offset, nxt_offset;
	logic [15:0] depth_q, cur_depth, nxt_depth;
	logic [31:0] fpos_q, cur_fpos, nxt_fpos;
	logic [15:0] col_q, cur_col, nxt_col;
	logic [15:0] row_q, cur_row, nxt_row;
	logic [17:0] row_pos_q, cur_row_pos, nxt_row_pos;
	logic [15:0] hold_q, cur_hold, nxt_hold;
	logic [1:0]  bip_q, cur_bip, nxt_bip;
	logic [17:0] row_len_q, nxt_row_len;
	logic [17:0] padded_q, nxt_padded;

	logic        start;
	logic        is24;
	logic        res_hit;
	logic [31:0] offs_fix;
	logic [17:0] len_calc;
	logic [17:0] pos1;
	logic [1:0]  bip_last;
	logic [7:0]  red, grn, blu;
	logic [15:0] color;
	logic        last_hit;
	logic        ended;

	// A first byte restarts the parse from a cleared view
	assign start       = item.first_byte;
	assign cur_phase   = start ? bmpr_pkg::PH_HEADER : phase_q;
	assign cur_cnt     = start ? '0 : hdr_cnt_q;
	assign cur_width   = start ? '0 : width_q;
	assign cur_height  = start ? '0 : height_q;
	assign cur_offset  = start ? '0 : offset_q;
	assign cur_depth   = start ? '0 : depth_q;
	assign cur_fpos    = start ? '0 : fpos_q;
	assign cur_col     = start ? '0 : col_q;
	assign cur_row     = start ? '0 : row_q;
	assign cur_row_pos = start ? '0 : row_pos_q;
	assign cur_hold    = start ? '0 : hold_q;
	assign cur_bip     = start ? '0 : bip_q;

	assign is24     = (cur_depth == bmpr_pkg::DEPTH_24);
	assign offs_fix = (cur_offset < bmpr_pkg::HDR_LEN) ? bmpr_pkg::HDR_LEN : cur_offset;
	// Row data length: width times 2 or 3 bytes
	assign len_calc = {1'b0, cur_width, 1'b0} + (is24 ? {2'b00, cur_width} : 18'd0);
	assign pos1     = cur_row_pos + 18'd1;
	assign bip_last = is24 ? 2'd2 : 2'd1;

	// Pixel packing: BGR888 to RGB565, or little-endian word pass-through
	assign red   = item.file_byte & bmpr_pkg::RED_BLUE_MASK;
	assign grn   = cur_hold[15:8] & bmpr_pkg::GREEN_MASK;
	assign blu   = cur_hold[7:0] & bmpr_pkg::RED_BLUE_MASK;
	assign color = is24 ? {red[7:3], grn[7:2], blu[7:3]} : {item.file_byte, cur_hold[7:0]};
	assign last_hit = ({1'b0, cur_row} + 17'd1 == {1'b0, cur_height}) &&
	                  ({1'b0, cur_col} + 17'd1 == {1'b0, cur_width});

	// Next state and result for the byte in stage 1
	always_comb begin
		nxt_phase   = cur_phase;
		nxt_cnt     = cur_cnt;
		nxt_width   = cur_width;
		nxt_height  = cur_height;
		nxt_offset  = cur_offset;
		nxt_depth   = cur_depth;
		nxt_fpos    = cur_fpos;
		nxt_col     = cur_col;
		nxt_row     = cur_row;
		nxt_row_pos = cur_row_pos;
		nxt_hold    = cur_hold;
		nxt_bip     = cur_bip;
		nxt_row_len = start ? '0 : row_len_q;
		nxt_padded  = start ? '0 : padded_q;
		res_hit     = 1'b0;
		res         = '0;
		ended       = 1'b0;
		case (cur_phase)
			bmpr_pkg::PH_HEADER: begin
				case (cur_cnt)
					bmpr_pkg::HB_OFFSET:         nxt_offset[7:0]   = item.file_byte;
					bmpr_pkg::HB_OFFSET + 6'd1:  nxt_offset[15:8]  = item.file_byte;
					bmpr_pkg::HB_OFFSET + 6'd2:  nxt_offset[23:16] = item.file_byte;
					bmpr_pkg::HB_OFFSET + 6'd3:  nxt_offset[31:24] = item.file_byte;
					bmpr_pkg::HB_WIDTH:          nxt_width[7:0]    = item.file_byte;
					bmpr_pkg::HB_WIDTH + 6'd1:   nxt_width[15:8]   = item.file_byte;
					bmpr_pkg::HB_HEIGHT:         nxt_height[7:0]   = item.file_byte;
					bmpr_pkg::HB_HEIGHT + 6'd1:  nxt_height[15:8]  = item.file_byte;
					bmpr_pkg::HB_DEPTH:          nxt_depth[7:0]    = item.file_byte;
					bmpr_pkg::HB_DEPTH + 6'd1:   nxt_depth[15:8]   = item.file_byte;
					default: ;
				endcase
				nxt_cnt  = cur_cnt + 6'd1;
				nxt_fpos = cur_fpos + 32'd1;
				// Last header byte: report and pick the next phase
				if (cur_cnt == bmpr_pkg::HDR_LAST) begin
					res_hit            = 1'b1;
					res.image_width    = cur_width;
					res.image_height   = cur_height;
					if (cur_depth != bmpr_pkg::DEPTH_24 && cur_depth != bmpr_pkg::DEPTH_16) begin
						res.kind  = bmpr_pkg::KIND_BAD_FORMAT;
						nxt_phase = bmpr_pkg::PH_DONE;
					end else begin
						res.kind    = bmpr_pkg::KIND_HEADER;
						nxt_offset  = offs_fix;
						nxt_row_len = len_calc;
						nxt_padded  = (len_calc + 18'd3) & ~18'd3;
						if (cur_width == '0 || cur_height == '0) begin
							nxt_phase = bmpr_pkg::PH_DONE;
						end else if (nxt_fpos >= offs_fix) begin
							nxt_phase = bmpr_pkg::PH_PIXELS;
						end else begin
							nxt_phase = bmpr_pkg::PH_SKIP;
						end
					end
				end
			end
			bmpr_pkg::PH_SKIP: begin
				nxt_fpos = cur_fpos + 32'd1;
				if (nxt_fpos >= cur_offset) begin
					nxt_phase = bmpr_pkg::PH_PIXELS;
				end
			end
			bmpr_pkg::PH_PIXELS: begin
				nxt_row_pos = pos1;
				if (cur_row_pos < row_len_q) begin
					if (cur_bip < bip_last) begin
						if (cur_bip == 2'd0) begin
							nxt_hold[7:0] = item.file_byte;
						end else begin
							nxt_hold[15:8] = item.file_byte;
						end
						nxt_bip = cur_bip + 2'd1;
					end else begin
						res_hit   = 1'b1;
						res.kind  = bmpr_pkg::KIND_PIXEL;
						res.pixel = color;
						nxt_hold  = '0;
						nxt_bip   = '0;
						if (last_hit) begin
							res.last_pixel = 1'b1;
							nxt_phase      = bmpr_pkg::PH_DONE;
							ended          = 1'b1;
						end else begin
							nxt_col = cur_col + 16'd1;
						end
					end
				end
				// End of padded row
				if (!ended && pos1 >= padded_q) begin
					nxt_row_pos = '0;
					nxt_col     = '0;
					nxt_row     = cur_row + 16'd1;
				end
			end
			default: ;
		endcase
	end

	assign res_valid = fire && res_hit;

	// Parse state, updated on every byte transfer out of stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= bmpr_pkg::PH_HEADER;
			hdr_cnt_q <= '0;
			width_q   <= '0;
			height_q  <= '0;
			offset_q  <= '0;
			depth_q   <= '0;
			fpos_q    <= '0;
			col_q     <= '0;
			row_q     <= '0;
			row_pos_q <= '0;
			hold_q    <= '0;
			bip_q     <= '0;
			row_len_q <= '0;
			padded_q  <= '0;
		end else if (fire) begin
			phase_q   <= nxt_phase;
			hdr_cnt_q <= nxt_cnt;
			width_q   <= nxt_width;
			height_q  <= nxt_height;
			offset_q  <= nxt_offset;
			depth_q   <= nxt_depth;
			fpos_q    <= nxt_fpos;
			col_q     <= nxt_col;
			row_q     <= nxt_row;
			row_pos_q <= nxt_row_pos;
			hold_q    <= nxt_hold;
			bip_q     <= nxt_bip;
			row_len_q <= nxt_row_len;
			padded_q  <= nxt_padded;
		end
	end

	`BMPR_ASSERT_IMPL(a_pixel_no_dims, res_valid && res.kind == bmpr_pkg::KIND_PIXEL, res.image_width == '0 && res.image_height == '0, "pixel result carries header dimensions")
	`BMPR_ASSERT_NEXT(a_last_ends_image, res_valid && res.last_pixel, phase_q == bmpr_pkg::PH_DONE, "parse not done after last pixel")
	`BMPR_ASSERT_IMPL(a_header_count, phase_q == bmpr_pkg::PH_HEADER, hdr_cnt_q <= bmpr_pkg::HDR_LAST, "header count ran past header end")
	`BMPR_ASSERT_IMPL(a_row_pos_bound, phase_q == bmpr_pkg::PH_PIXELS, row_pos_q < padded_q, "row position beyond padded row length")

endmodule

>>> hdl/bmpr_out_stage.sv
// Result register of the BMP to RGB565 stream unit.
// Uses bmpr_pkg.
module bmpr_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  bmpr_pkg::result_t res,
	input  logic              result_stall,
	output logic              advance,
	output logic              result_valid,
	output bmpr_pkg::result_t result_q
);

	// Slot is free when empty or being drained this cycle
	assign advance = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			result_q <= res;
		end
	end

endmodule

>>> hdl/bmp_to_rgb565_stream_unit.sv
// BMP to RGB565 stream unit: takes one file byte per transfer and sustains one byte per
// clock while result_stall is low; each byte passes an input register and the parse
// logic into a result register, where its result is offered. While a result waits on
// result_stall, the byte behind it stays in the input register and byte_stall is raised.
// The byte rate is set by the single pass of header capture, skip counting and pixel
// packing done per byte. At most one result comes from a byte: the header (kind 0) or
// format error (kind 2) at header byte 53, and one RGB565 pixel (kind 1) when the last
// byte of a pixel arrives.
// Uses bmpr_pkg, bmpr_in_stage, bmpr_parser, bmpr_out_stage.
module bmp_to_rgb565_stream_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  file_byte,
	input  logic        first_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic [15:0] pixel,
	output logic        last_pixel
);

	logic               advance;
	logic               valid_s1;
	logic               fire;
	logic               res_valid;
	bmpr_pkg::in_item_t item_s1;
	bmpr_pkg::result_t  res;
	bmpr_pkg::result_t  result_q;

	bmpr_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.file_byte  (file_byte),
		.first_byte (first_byte),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	// Stage 1 byte is consumed whenever the result slot can take its outcome
	assign fire = valid_s1 && advance;

	bmpr_parser u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	bmpr_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res          (res),
		.result_stall (result_stall),
		.advance      (advance),
		.result_valid (result_valid),
		.result_q     (result_q)
	);

	assign kind         = result_q.kind;
	assign image_width  = result_q.image_width;
	assign image_height = result_q.image_height;
	assign pixel        = result_q.pixel;
	assign last_pixel   = result_q.last_pixel;

endmodule
